// ----- sv/cubic_lagrange_curve_resampler_macros.svh -----
// assertion helpers for the curve resampler
`ifndef CUBIC_LAGRANGE_CURVE_RESAMPLER_MACROS_SVH
`define CUBIC_LAGRANGE_CURVE_RESAMPLER_MACROS_SVH

// same-cycle implication
`define CLCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clcr check failed");

// next-cycle implication
`define CLCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clcr check failed");

`endif

// ----- sv/clcr_pkg.sv -----
package clcr_pkg;

  localparam int COORD_W  = 24;
  localparam int T_W      = 17;
  localparam int EVAL_LAT = 7;
  localparam int SQ_IN_W  = 50;
  localparam int LEN_W    = 25;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [7:0] pts;
    logic [23:0]  spacing;
  } req_t;

  typedef struct packed {
    logic       emit;
    logic       first;
    logic       last;
    logic [5:0] idx;
  } eval_tag_t;

endpackage

// ----- sv/cubic_lagrange_curve_resampler.sv -----
// Takes a request (four curve points and a spacing) on start while busy is low; two requests
// can wait in the front queue. Each request runs LENGTH_SAMPLES+1 curve evaluations through a
// 7-stage evaluator, one per cycle, and the chords through a 25-stage square root, then two
// divisions on the shared divider, then one point per cycle. Results leave on point_valid
// for one cycle each and cannot be held off: the start point first, the final one with
// last_point set.
`include "cubic_lagrange_curve_resampler_macros.svh"

module cubic_lagrange_curve_resampler #(
  parameter int LENGTH_SAMPLES = 100,
  parameter int MAX_POINTS     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] start_x,
  input  logic [23:0] start_y,
  input  logic [23:0] ctrl1_x,
  input  logic [23:0] ctrl1_y,
  input  logic [23:0] ctrl2_x,
  input  logic [23:0] ctrl2_y,
  input  logic [23:0] end_x,
  input  logic [23:0] end_y,
  input  logic [23:0] max_spacing,
  output logic        point_valid,
  output logic [23:0] point_x,
  output logic [23:0] point_y,
  output logic [5:0]  point_index,
  output logic        last_point
);
  import clcr_pkg::*;

  localparam int LS_W = $clog2(LENGTH_SAMPLES + 1);
  localparam int SQ0  = 65536 / LENGTH_SAMPLES;
  localparam int SR0  = 65536 % LENGTH_SAMPLES;
  localparam logic [5:0] STEP_MAX = 6'(MAX_POINTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SAMPLE, ST_WAIT_LEN, ST_DIV_LEN, ST_DIV_T, ST_EMIT, ST_DRAIN
  } state_t;

  state_t    state;
  req_t      req_in, head, cur;
  logic      avail, pop;

  logic            iss_valid;
  logic [T_W-1:0]  iss_t;
  eval_tag_t       iss_tag;
  logic            ev_valid;
  eval_tag_t       ev_tag;
  coord_t          ev_x, ev_y;

  logic [LS_W-1:0] scount, chord_cnt;
  logic [LS_W:0]   srem_sum;
  logic [LS_W-1:0] srem;
  logic [T_W-1:0]  tval;

  logic [5:0]  steps, ecount;
  logic [6:0]  erem, erem0;
  logic [7:0]  erem_sum;
  logic [T_W-1:0] eq0;
  logic [2:0]  drain;

  logic        div_start, div_done;
  logic [31:0] div_a, div_q;
  logic [23:0] div_b, div_r;
  logic [5:0]  steps_calc;

  coord_t             prev_x, prev_y;
  logic               c1_vld, c2_vld;
  logic signed [24:0] dx, dy;
  logic [SQ_IN_W-1:0] sq;
  logic               rt_vld;
  logic [LEN_W-1:0]   rt;
  logic [31:0]        arc_sum;
  logic [32:0]        arc_add;

  assign req_in.pts     = {end_y, end_x, ctrl2_y, ctrl2_x, ctrl1_y, ctrl1_x, start_y, start_x};
  assign req_in.spacing = max_spacing;
  assign pop            = (state == ST_IDLE) && avail;

  clcr_front u_front (
    .clk, .rst, .start, .req_in, .busy, .pop, .avail, .head
  );

  clcr_eval u_eval (
    .clk, .rst,
    .in_valid (iss_valid),
    .in_t     (iss_t),
    .in_tag   (iss_tag),
    .pts      (cur.pts),
    .out_valid(ev_valid),
    .out_tag  (ev_tag),
    .out_x    (ev_x),
    .out_y    (ev_y)
  );

  clcr_sqrt u_sqrt (
    .clk, .rst,
    .in_valid (c2_vld),
    .in_val   (sq),
    .out_valid(rt_vld),
    .out_root (rt)
  );

  clcr_div u_div (
    .clk, .rst,
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign point_valid = ev_valid && ev_tag.emit;
  assign point_x     = ev_x;
  assign point_y     = ev_y;
  assign point_index = ev_tag.idx;
  assign last_point  = ev_tag.last;

  always_comb begin
    if (div_q == '0) begin
      steps_calc = 6'd1;
    end else if (div_q > 32'(STEP_MAX)) begin
      steps_calc = STEP_MAX;
    end else begin
      steps_calc = div_q[5:0];
    end
    srem_sum = {1'b0, srem} + (LS_W+1)'(SR0);
    erem_sum = {1'b0, erem} + {1'b0, erem0};
    arc_add  = {1'b0, arc_sum} + 33'(rt);
  end

  // chord path
  always_ff @(posedge clk) begin
    sq <= SQ_IN_W'(50'(dx) * 50'(dx)) + SQ_IN_W'(50'(dy) * 50'(dy));
    if (ev_valid && !ev_tag.emit) begin
      prev_x <= ev_x;
      prev_y <= ev_y;
      dx     <= 25'(ev_x) - 25'(prev_x);
      dy     <= 25'(ev_y) - 25'(prev_y);
    end
    if (rst) begin
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
    end else begin
      c1_vld <= ev_valid && !ev_tag.emit && !ev_tag.first;
      c2_vld <= c1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iss_valid <= 1'b0;
      div_start <= 1'b0;
      arc_sum   <= '0;
      chord_cnt <= '0;
      scount    <= '0;
      steps     <= '0;
      ecount    <= '0;
      drain     <= '0;
    end else begin
      iss_valid <= 1'b0;
      div_start <= 1'b0;
      if (rt_vld) begin
        arc_sum   <= arc_add[32] ? 32'hFFFF_FFFF : arc_add[31:0];
        chord_cnt <= chord_cnt + LS_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (avail) begin
            cur       <= head;
            arc_sum   <= '0;
            chord_cnt <= '0;
            scount    <= '0;
            srem      <= '0;
            tval      <= '0;
            state     <= ST_SAMPLE;
          end
        end
        ST_SAMPLE: begin
          iss_valid     <= 1'b1;
          iss_t         <= tval;
          iss_tag.emit  <= 1'b0;
          iss_tag.first <= (scount == '0);
          iss_tag.last  <= 1'b0;
          iss_tag.idx   <= '0;
          if (srem_sum >= (LS_W+1)'(LENGTH_SAMPLES)) begin
            srem <= LS_W'(srem_sum - (LS_W+1)'(LENGTH_SAMPLES));
            tval <= tval + T_W'(SQ0 + 1);
          end else begin
            srem <= srem_sum[LS_W-1:0];
            tval <= tval + T_W'(SQ0);
          end
          scount <= scount + LS_W'(1);
          if (scount == LS_W'(LENGTH_SAMPLES)) begin
            state <= ST_WAIT_LEN;
          end
        end
        ST_WAIT_LEN: begin
          if (chord_cnt == LS_W'(LENGTH_SAMPLES)) begin
            div_a     <= arc_sum;
            div_b     <= cur.spacing;
            div_start <= 1'b1;
            state     <= ST_DIV_LEN;
          end
        end
        ST_DIV_LEN: begin
          if (div_done) begin
            steps     <= steps_calc;
            div_a     <= 32'h0001_0000;
            div_b     <= 24'(steps_calc) + 24'd1;
            div_start <= 1'b1;
            state     <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_done) begin
            eq0    <= div_q[T_W-1:0];
            erem0  <= div_r[6:0];
            erem   <= '0;
            tval   <= '0;
            ecount <= '0;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          iss_valid     <= 1'b1;
          iss_t         <= tval;
          iss_tag.emit  <= 1'b1;
          iss_tag.first <= 1'b0;
          iss_tag.last  <= (ecount == steps);
          iss_tag.idx   <= ecount;
          if (erem_sum >= 8'(steps) + 8'd1) begin
            erem <= 7'(erem_sum - 8'(steps) - 8'd1);
            tval <= tval + eq0 + T_W'(1);
          end else begin
            erem <= erem_sum[6:0];
            tval <= tval + eq0;
          end
          ecount <= ecount + 6'd1;
          if (ecount == steps) begin
            drain <= 3'(EVAL_LAT);
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain <= drain - 3'd1;
          if (drain == 3'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CLCR_ASSERT_NOW(a_emit_in_flow, clk, rst, point_valid, (state == ST_EMIT || state == ST_DRAIN || state == ST_IDLE))
  `CLCR_ASSERT_NOW(a_last_at_end, clk, rst, point_valid && last_point, point_index == steps)
  `CLCR_ASSERT_NOW(a_no_chord_while_emit, clk, rst, point_valid, !rt_vld && !c1_vld)
  `CLCR_ASSERT_NEXT(a_pop_starts, clk, rst, pop, state == ST_SAMPLE)

endmodule

// ----- sv/clcr_front.sv -----
module clcr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  clcr_pkg::req_t req_in,
  output logic          busy,
  input  logic          pop,
  output logic          avail,
  output clcr_pkg::req_t head
);
  import clcr_pkg::*;

  req_t       slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  req_t       fixed;

  always_comb begin
    fixed = req_in;
    if (req_in.spacing == '0) begin
      fixed.spacing = 24'd1;
    end
  end

  assign busy  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign push  = start && !busy;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= fixed;
    end
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && avail) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop && avail);
    end
  end
endmodule

// ----- sv/clcr_div.sv -----
module clcr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [23:0] remainder
);
  logic [31:0] quo;
  logic [23:0] rem;
  logic [23:0] dvs;
  logic [5:0]  cnt;
  logic        running;
  logic [24:0] shifted;
  logic        fits;

  assign shifted   = {rem, quo[31]};
  assign fits      = (shifted >= {1'b0, dvs});
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= dividend;
        rem     <= '0;
        dvs     <= divisor;
        cnt     <= 6'd32;
        running <= 1'b1;
      end else if (running) begin
        if (fits) begin
          rem <= 24'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[23:0];
        end
        quo <= {quo[30:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/clcr_sqrt.sv -----
module clcr_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [clcr_pkg::SQ_IN_W-1:0] in_val,
  output logic                        out_valid,
  output logic [clcr_pkg::LEN_W-1:0]  out_root
);
  import clcr_pkg::*;

  logic [SQ_IN_W-1:0] val  [LEN_W+1];
  logic [27:0]        rem  [LEN_W+1];
  logic [LEN_W-1:0]   root [LEN_W+1];
  logic               vld  [LEN_W+1];

  assign val[0]  = in_val;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign vld[0]  = in_valid;

  for (genvar i = 0; i < LEN_W; i++) begin : g_stage
    logic [27:0] rshift;
    logic [27:0] trial;
    assign rshift = {rem[i][25:0], val[i][SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, root[i], 2'b01};
    always_ff @(posedge clk) begin
      val[i+1] <= {val[i][SQ_IN_W-3:0], 2'b00};
      if (rshift >= trial) begin
        rem[i+1]  <= rshift - trial;
        root[i+1] <= {root[i][LEN_W-2:0], 1'b1};
      end else begin
        rem[i+1]  <= rshift;
        root[i+1] <= {root[i][LEN_W-2:0], 1'b0};
      end
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[LEN_W];
  assign out_root  = root[LEN_W];
endmodule

// ----- sv/clcr_eval.sv -----
module clcr_eval (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [clcr_pkg::T_W-1:0]     in_t,
  input  clcr_pkg::eval_tag_t          in_tag,
  input  clcr_pkg::coord_t [7:0]       pts,
  output logic                         out_valid,
  output clcr_pkg::eval_tag_t          out_tag,
  output clcr_pkg::coord_t             out_x,
  output clcr_pkg::coord_t             out_y
);
  import clcr_pkg::*;

  logic      vld [EVAL_LAT];
  eval_tag_t tag [EVAL_LAT];

  logic [19:0]        u3;
  logic signed [19:0] s1_u, s1_a, s1_b, s1_c;
  logic signed [19:0] s2_u, s2_a, s2_b, s2_c;
  logic signed [39:0] s2_au, s2_bc;
  logic signed [59:0] s3_n [4];
  logic [22:0]        s4_m [4];
  logic               s4_neg [4];
  logic signed [23:0] s5_b [4];
  logic signed [47:0] s6_px [4];
  logic signed [47:0] s6_py [4];
  logic [59:0]        mag [4];
  logic [54:0]        p0, p3;
  logic [22:0]        q [4];
  logic signed [50:0] sx, sy;
  logic signed [34:0] rx, ry;

  assign u3 = {3'b000, in_t} + {2'b00, in_t, 1'b0};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = s3_n[i][59] ? 60'(-s3_n[i]) : 60'(s3_n[i]);
    end
    p0   = 55'(s4_m[0]) * 55'(RECIP3);
    p3   = 55'(s4_m[3]) * 55'(RECIP3);
    q[0] = {2'b00, p0[54:34]};
    q[1] = s4_m[1];
    q[2] = s4_m[2];
    q[3] = {2'b00, p3[54:34]};
    sx = 51'(s6_px[0]) + 51'(s6_px[1]) + 51'(s6_px[2]) + 51'(s6_px[3]) + 51'sd32768;
    sy = 51'(s6_py[0]) + 51'(s6_py[1]) + 51'(s6_py[2]) + 51'(s6_py[3]) + 51'sd32768;
    rx = 35'(sx >>> 16);
    ry = 35'(sy >>> 16);
  end

  always_ff @(posedge clk) begin
    s1_u <= signed'(u3);
    s1_a <= signed'(u3) - 20'sd65536;
    s1_b <= signed'(u3) - 20'sd131072;
    s1_c <= signed'(u3) - 20'sd196608;

    s2_u  <= s1_u;
    s2_a  <= s1_a;
    s2_b  <= s1_b;
    s2_c  <= s1_c;
    s2_au <= s1_u * s1_a;
    s2_bc <= s1_b * s1_c;

    s3_n[0] <= 60'(s2_a) * 60'(s2_bc);
    s3_n[1] <= 60'(s2_u) * 60'(s2_bc);
    s3_n[2] <= 60'(s2_au) * 60'(s2_c);
    s3_n[3] <= 60'(s2_au) * 60'(s2_b);

    s4_m[0] <= mag[0][54:32];
    s4_m[1] <= mag[1][55:33];
    s4_m[2] <= mag[2][55:33];
    s4_m[3] <= mag[3][54:32];
    for (int i = 0; i < 4; i++) begin
      s4_neg[i] <= s3_n[i][59];
    end

    // basis weights, minus signs on the first and third terms
    s5_b[0] <= s4_neg[0] ? 24'(q[0]) : -24'(q[0]);
    s5_b[1] <= s4_neg[1] ? -24'(q[1]) : 24'(q[1]);
    s5_b[2] <= s4_neg[2] ? 24'(q[2]) : -24'(q[2]);
    s5_b[3] <= s4_neg[3] ? -24'(q[3]) : 24'(q[3]);

    for (int i = 0; i < 4; i++) begin
      s6_px[i] <= 48'(pts[2*i]) * 48'(s5_b[i]);
      s6_py[i] <= 48'(pts[2*i+1]) * 48'(s5_b[i]);
    end

    if (rx > 35'sd8388607) begin
      out_x <= 24'sh7FFFFF;
    end else if (rx < -35'sd8388608) begin
      out_x <= 24'sh800000;
    end else begin
      out_x <= rx[23:0];
    end
    if (ry > 35'sd8388607) begin
      out_y <= 24'sh7FFFFF;
    end else if (ry < -35'sd8388608) begin
      out_y <= 24'sh800000;
    end else begin
      out_y <= ry[23:0];
    end

    tag[0] <= in_tag;
    for (int i = 1; i < EVAL_LAT; i++) begin
      tag[i] <= tag[i-1];
    end
    if (rst) begin
      for (int i = 0; i < EVAL_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < EVAL_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign out_valid = vld[EVAL_LAT-1];
  assign out_tag   = tag[EVAL_LAT-1];
endmodule

// ----- sim/clcr_checker.sv -----
`timescale 1ns / 100ps

module clcr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [23:0] start_x,
  input  logic [23:0] start_y,
  input  logic [23:0] ctrl1_x,
  input  logic [23:0] ctrl1_y,
  input  logic [23:0] ctrl2_x,
  input  logic [23:0] ctrl2_y,
  input  logic [23:0] end_x,
  input  logic [23:0] end_y,
  input  logic [23:0] max_spacing,
  input  logic        point_valid,
  input  logic [23:0] point_x,
  input  logic [23:0] point_y,
  input  logic [5:0]  point_index,
  input  logic        last_point,
  output int          errors,
  output int          pending,
  output int          points_seen,
  output int          requests_seen
);

  localparam int SAMPLES = 100;
  localparam int MAX_PTS = 64;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [5:0]  idx;
    logic        last;
  } curve_point_t;

  curve_point_t expected_points[$];
  longint       ctl_pts[8];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_sat(longint v);
    longint a;
    longint r;
    a = v + 32768;
    if (a >= 0) r = a / 65536;
    else r = -((-a + 65535) / 65536);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  // lagrange interpolation at nodes 0, 1/3, 2/3, 1
  task automatic curve_at(input longint t, output longint px, output longint py);
    longint f;
    longint den;
    longint u;
    longint w[4];
    longint sx;
    longint sy;
    f = 65536;
    den = 64'sd1 << 32;
    u = 3 * t;
    w[0] = -(((u - f) * (u - 2 * f) * (u - 3 * f)) / (6 * den));
    w[1] = (u * (u - 2 * f) * (u - 3 * f)) / (2 * den);
    w[2] = -((u * (u - f) * (u - 3 * f)) / (2 * den));
    w[3] = (u * (u - f) * (u - 2 * f)) / (6 * den);
    sx = 0;
    sy = 0;
    for (int i = 0; i < 4; i++) begin
      sx += ctl_pts[2 * i] * w[i];
      sy += ctl_pts[2 * i + 1] * w[i];
    end
    px = round_sat(sx);
    py = round_sat(sy);
  endtask

  task automatic predict_run(input logic [23:0] raw[9]);
    longint spacing;
    longint unsigned arc_len;
    longint steps;
    longint px;
    longint py;
    longint x;
    longint y;
    longint dx;
    longint dy;
    curve_point_t p;
    for (int i = 0; i < 8; i++) ctl_pts[i] = longint'($signed(raw[i]));
    spacing = longint'(raw[8]);
    if (spacing == 0) spacing = 1;
    px = ctl_pts[0];
    py = ctl_pts[1];
    arc_len = 0;
    for (int s = 1; s <= SAMPLES; s++) begin
      curve_at((longint'(s) * 65536) / SAMPLES, x, y);
      dx = x - px;
      dy = y - py;
      arc_len += int_sqrt(longint'(dx * dx) + longint'(dy * dy));
      if (arc_len > 64'hFFFF_FFFF) arc_len = 64'hFFFF_FFFF;
      px = x;
      py = y;
    end
    steps = longint'(arc_len / spacing);
    if (steps < 1) steps = 1;
    if (steps > MAX_PTS - 1) steps = MAX_PTS - 1;
    p.x = ctl_pts[0][23:0];
    p.y = ctl_pts[1][23:0];
    p.idx = 0;
    p.last = 0;
    expected_points.push_back(p);
    for (int s = 1; s <= steps; s++) begin
      curve_at((longint'(s) * 65536) / (steps + 1), x, y);
      p.x = x[23:0];
      p.y = y[23:0];
      p.idx = s[5:0];
      p.last = (s == steps);
      expected_points.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    logic [23:0]  req[9];
    curve_point_t e;
    if (rst) begin
      expected_points.delete();
      errors <= 0;
      points_seen <= 0;
      requests_seen <= 0;
    end else begin
      if (point_valid) begin
        points_seen <= points_seen + 1;
        if (expected_points.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected point transfer: x %h y %h idx %0d last %b",
                                    point_x, point_y, point_index, last_point);
        end else begin
          e = expected_points.pop_front();
          if (e.x !== point_x || e.y !== point_y || e.idx !== point_index ||
              e.last !== last_point) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("point mismatch: exp x %h y %h idx %0d last %b, got x %h y %h idx %0d last %b",
                       e.x, e.y, e.idx, e.last, point_x, point_y, point_index, last_point);
          end
        end
      end
      if (start && !busy) begin
        req = '{start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
                max_spacing};
        predict_run(req);
        requests_seen <= requests_seen + 1;
      end
    end
    pending <= expected_points.size();
  end

endmodule

// ----- sim/cubic_lagrange_curve_resampler_tb.sv -----
`timescale 1ns / 100ps

module cubic_lagrange_curve_resampler_tb;

  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [23:0] start_x = 0, start_y = 0, ctrl1_x = 0, ctrl1_y = 0;
  logic [23:0] ctrl2_x = 0, ctrl2_y = 0, end_x = 0, end_y = 0;
  logic [23:0] max_spacing = 1;
  logic        point_valid;
  logic [23:0] point_x, point_y;
  logic [5:0]  point_index;
  logic        last_point;
  int          errors, pending, points_seen, requests_seen;
  int          cycles = 0;
  int          idle_pct = 0;

  always #5 clk = ~clk;

  cubic_lagrange_curve_resampler i_dut (.*);

  clcr_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cubic_lagrange_curve_resampler_tb: FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic [23:0] p[8], input logic [23:0] sp);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    {start_x, start_y, ctrl1_x, ctrl1_y} = {p[0], p[1], p[2], p[3]};
    {ctrl2_x, ctrl2_y, end_x, end_y} = {p[4], p[5], p[6], p[7]};
    max_spacing = sp;
    start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(3))
      0: return v;
      1: return v >>> 8;
      2: return v >>> 14;
      default: return v >>> $urandom_range(23);
    endcase
  endfunction

  function automatic logic [23:0] rand_spacing();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(1, 16));
      default: return 24'($urandom_range(1, (1 << $urandom_range(1, 23))));
    endcase
  endfunction

  initial begin
    logic [23:0] pts[8];
    logic [23:0] mx, mn;
    int          idle_by_phase[4];
    mx = 24'h7FFFFF;
    mn = 24'h800000;
    idle_by_phase = '{0, 81, 0, 35};
    repeat (7) @(negedge clk);
    rst = 0;

    // straight line, zero spacing, long curve saturating the step count
    pts = '{0, 0, 24'd256, 24'd256, 24'd512, 24'd512, 24'd768, 24'd768};
    send_request(pts, 0);
    send_request(pts, 1);
    // short curve, huge spacing
    send_request(pts, 24'hFFFFFF);
    // degenerate curve, all points equal
    pts = '{mx, mn, mx, mn, mx, mn, mx, mn};
    send_request(pts, 1);
    send_request(pts, 24'hFFFFFF);
    // overshooting control points drive coordinates into saturation
    pts = '{0, 0, mx, mn, mn, mx, 0, 0};
    send_request(pts, 1);
    pts = '{mn, mx, mx, mn, mn, mx, mx, mn};
    send_request(pts, 1);
    pts = '{mx, mx, mn, mn, mx, mx, mn, mn};
    send_request(pts, 24'h000100);
    pts = '{mn, mn, mn, mn, mx, mx, mx, mx};
    send_request(pts, 24'h800000);
    pts = '{0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1, 0, 0};
    send_request(pts, 1);
    send_request(pts, 24'd2);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = idle_by_phase[i * 4 / RANDOM_ITEMS];
      foreach (pts[k]) pts[k] = rand_coord();
      send_request(pts, rand_spacing());
    end
    start = 0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("requests sent: %0d, curve points checked: %0d, with random idle phases",
             requests_seen, points_seen);
    if (errors == 0 && pending == 0) begin
      $display("cubic_lagrange_curve_resampler_tb: PASS");
    end else begin
      $display("mismatches: %0d", errors);
      $display("cubic_lagrange_curve_resampler_tb: FAIL");
    end
    $finish;
  end

endmodule
